@@ rtl/core/elg_pkg.sv @@
// ============================================================================
// elg_pkg
// Shared types and constants of the modular exponentiation cipher.
// ============================================================================
`default_nettype none
package elg_pkg;
   localparam int WORD_BITS = 32;
   localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

   typedef logic [WORD_BITS-1:0] word_type;

   localparam logic [1:0] CSR_MODULUS     = 2'd0;
   localparam logic [1:0] CSR_GENERATOR   = 2'd1;
   localparam logic [1:0] CSR_PUBLIC_KEY  = 2'd2;
   localparam logic [1:0] CSR_PRIVATE_KEY = 2'd3;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef struct packed {
      logic     cmd;
      word_type data_value;
      word_type ephemeral_exponent;
      word_type cipher_first;
   } req_type;

   typedef struct packed {
      word_type first_part;
      word_type result_value;
   } rsp_type;

   // request to the modular multiplier
   typedef struct packed {
      logic start;
   } mul_ctl_type;
endpackage
`default_nettype wire

@@ rtl/core/elg_modmul.sv @@
// ============================================================================
// elg_modmul
// Bit-serial modular multiplier: (a * b) mod p by double-and-add, one bit of
// b per cycle, most significant first. Also used with a = 1 as a reducer.
// ============================================================================
`default_nettype none
module elg_modmul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire elg_pkg::mul_ctl_type ctl,
   input  wire elg_pkg::word_type    a,
   input  wire elg_pkg::word_type    b,
   input  wire elg_pkg::word_type    p,
   output logic                      done,
   output elg_pkg::word_type         prod
);
   logic                            busy_ff, busy_in;
   logic [elg_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [elg_pkg::WORD_BITS:0]     ra_ff, ra_in;
   elg_pkg::word_type               rb_ff, rb_in;
   logic [elg_pkg::WORD_BITS:0]     acc_ff, acc_in;
   logic                            done_ff, done_in;
   logic [elg_pkg::WORD_BITS+1:0]   dbl, sum, dsub, ssub;
   logic [elg_pkg::WORD_BITS:0]     pw, red, red2;

   assign pw = {1'b0, p};

   // one double-and-add step, each half reduced by one compare/subtract
   always_comb begin
      dbl  = {acc_ff, 1'b0};
      dsub = dbl - {1'b0, pw};
      red  = (dbl >= {1'b0, pw}) ? dsub[elg_pkg::WORD_BITS:0] : dbl[elg_pkg::WORD_BITS:0];
      sum  = {1'b0, red} + (rb_ff[elg_pkg::WORD_BITS-1] ? {1'b0, ra_ff} : '0);
      ssub = sum - {1'b0, pw};
      red2 = (sum >= {1'b0, pw}) ? ssub[elg_pkg::WORD_BITS:0] : sum[elg_pkg::WORD_BITS:0];
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         ra_in   = {1'b0, a};
         rb_in   = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = red2;
         rb_in  = {rb_ff[elg_pkg::WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == elg_pkg::CNT_BITS'(elg_pkg::WORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff[elg_pkg::WORD_BITS-1:0];
endmodule
`default_nettype wire

@@ rtl/core/elgamal_modexp_cipher.sv @@
// ============================================================================
// elgamal_modexp_cipher
// ElGamal encrypt/decrypt unit on square-and-multiply exponentiation.
// ============================================================================
// Usage:
//   csr_*  : write modulus, generator, public key, private key (index 0..3)
//            only while busy is low.
//   req_*  : a transfer happens when start is high and busy is low; the next
//            transfer can be taken in the cycle the result strobe is high.
//   rsp_*  : rsp_valid pulses one cycle with first_part / result_value;
//            the receiver cannot stall, the result is dropped if not taken.
// Sequencing: all products come from the single shared bit-serial
//   multiplier, which a state launches and a wait state holds until done.
//   Each power starts with a full reduction of its base as 1 * base mod p,
//   then for each exponent bit squares the base, first multiplying it into
//   the accumulator when the bit is set. An encrypt computes two powers, a
//   decrypt one, after x mod (p-1) by a restoring loop; when p is below 2
//   the unit goes straight to S_OUT with a zero result.
// Reset: registers return to p = 4294967291, g = 2, y = 1, x = 1, idle.
// ============================================================================
`default_nettype none
module elgamal_modexp_cipher (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire elg_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output elg_pkg::rsp_type       rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire elg_pkg::word_type csr_wdata
);
   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_XMOD  = 12'b000000000010,
      S_RBASE = 12'b000000000100,
      S_LOOP  = 12'b000000001000,
      S_MUL   = 12'b000000010000,
      S_SQR   = 12'b000000100000,
      S_FIN   = 12'b000001000000,
      S_DATA  = 12'b000010000000,
      S_OUT   = 12'b000100000000,
      S_WAITB = 12'b001000000000,
      S_WAITM = 12'b010000000000,
      S_WAITS = 12'b100000000000
   } state_type;

   elg_pkg::word_type mod_ff, gen_ff, pub_ff, prv_ff;
   state_type         st_ff, st_in;
   logic              pass_ff, pass_in;       // 0: first power, 1: second (decrypt: sole)
   elg_pkg::word_type data_ff, data_in, rexp_ff, rexp_in, c1_ff, c1_in;
   elg_pkg::word_type exp_ff, exp_in, base_ff, base_in, acc_ff, acc_in;
   elg_pkg::word_type first_ff, first_in;
   elg_pkg::word_type rem_ff, rem_in;
   logic [elg_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic              bz_ff, bz_in;
   logic              vld_ff, vld_in;
   elg_pkg::word_type res_ff, res_in;
   elg_pkg::mul_ctl_type mctl;
   elg_pkg::word_type ma, mb, mprod;
   logic              mdone;
   elg_pkg::word_type pm1;
   logic [elg_pkg::WORD_BITS:0] rsh, rsub;

   elg_modmul u_mul (
      .clock (clock), .reset (reset), .ctl (mctl), .a (ma), .b (mb),
      .p (mod_ff), .done (mdone), .prod (mprod)
   );

   assign pm1  = mod_ff - 1'b1;
   assign busy = (st_ff != S_IDLE);
   // one restoring step of x mod (p-1), x bits fed from exp_ff
   assign rsh  = {rem_ff, exp_ff[elg_pkg::WORD_BITS-1]};
   assign rsub = rsh - {1'b0, pm1};

   // cheap first subtract ahead of the full 1 * base reduction
   function automatic elg_pkg::word_type pre(input elg_pkg::word_type v,
                                             input elg_pkg::word_type m);
      pre = (v >= m) ? v - m : v;
   endfunction

   always_comb begin
      st_in = st_ff; pass_in = pass_ff;
      data_in = data_ff; rexp_in = rexp_ff; c1_in = c1_ff;
      exp_in = exp_ff; base_in = base_ff; acc_in = acc_ff;
      first_in = first_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      bz_in = bz_ff; vld_in = 1'b0; res_in = res_ff;
      mctl.start = 1'b0; ma = base_ff; mb = base_ff;
      unique case (st_ff)
         S_IDLE: if (start) begin
            data_in = req_data.data_value;
            rexp_in = req_data.ephemeral_exponent;
            c1_in   = req_data.cipher_first;
            pass_in = 1'b0;
            first_in = '0;
            if (mod_ff < 32'd2) begin
               res_in = '0; st_in = S_OUT;
            end else if (req_data.cmd == elg_pkg::CMD_DECRYPT) begin
               exp_in = prv_ff; rem_in = '0; cnt_in = '0; st_in = S_XMOD;
            end else begin
               exp_in = req_data.ephemeral_exponent;
               base_in = pre(gen_ff, mod_ff); st_in = S_RBASE;
            end
         end
         S_XMOD: begin
            rem_in = rsub[elg_pkg::WORD_BITS] ? rsh[elg_pkg::WORD_BITS-1:0]
                                              : rsub[elg_pkg::WORD_BITS-1:0];
            exp_in = {exp_ff[elg_pkg::WORD_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == elg_pkg::CNT_BITS'(elg_pkg::WORD_BITS - 1)) begin
               exp_in = pm1 - (rsub[elg_pkg::WORD_BITS] ? rsh[elg_pkg::WORD_BITS-1:0]
                                                        : rsub[elg_pkg::WORD_BITS-1:0]);
               base_in = pre(c1_ff, mod_ff);
               pass_in = 1'b1;
               st_in = S_RBASE;
            end
         end
         S_RBASE: begin
            // full reduction: 1 * base mod p
            mctl.start = 1'b1; ma = 32'd1; mb = base_ff; st_in = S_WAITB;
         end
         S_WAITB: if (mdone) begin
            base_in = mprod; bz_in = (mprod == '0);
            acc_in = 32'd1; cnt_in = '0; st_in = S_LOOP;
         end
         S_LOOP: begin
            if (cnt_ff == elg_pkg::CNT_BITS'(elg_pkg::WORD_BITS)) st_in = S_FIN;
            else if (exp_ff[0]) begin
               mctl.start = 1'b1; ma = acc_ff; mb = base_ff; st_in = S_WAITM;
            end else st_in = S_SQR;
         end
         S_WAITM: if (mdone) begin acc_in = mprod; st_in = S_SQR; end
         S_SQR: begin
            mctl.start = 1'b1; ma = base_ff; mb = base_ff; st_in = S_WAITS;
         end
         S_WAITS: if (mdone) begin
            base_in = mprod; exp_in = exp_ff >> 1; cnt_in = cnt_ff + 1'b1;
            st_in = S_LOOP;
         end
         S_FIN: begin
            acc_in = bz_ff ? '0 : acc_ff;
            if (!pass_ff) begin
               first_in = bz_ff ? '0 : acc_ff;
               exp_in = rexp_ff; base_in = pre(pub_ff, mod_ff);
               pass_in = 1'b1; st_in = S_RBASE;
            end else begin
               mctl.start = 1'b1; ma = bz_ff ? '0 : acc_ff;
               mb = data_ff; st_in = S_DATA;
            end
         end
         S_DATA: if (mdone) begin res_in = mprod; st_in = S_OUT; end
         S_OUT: begin vld_in = 1'b1; st_in = S_IDLE; end
         default: st_in = S_IDLE;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= 32'd4294967291; gen_ff <= 32'd2;
         pub_ff <= 32'd1;          prv_ff <= 32'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            elg_pkg::CSR_MODULUS:     mod_ff <= csr_wdata;
            elg_pkg::CSR_GENERATOR:   gen_ff <= csr_wdata;
            elg_pkg::CSR_PUBLIC_KEY:  pub_ff <= csr_wdata;
            elg_pkg::CSR_PRIVATE_KEY: prv_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in;
      end
      pass_ff <= pass_in; data_ff <= data_in;
      rexp_ff <= rexp_in; c1_ff <= c1_in; exp_ff <= exp_in;
      base_ff <= base_in; acc_ff <= acc_in; first_ff <= first_in;
      rem_ff <= rem_in; cnt_ff <= cnt_in; bz_ff <= bz_in; res_ff <= res_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_data.first_part   = first_ff;
   assign rsp_data.result_value = res_ff;
endmodule
`default_nettype wire

@@ rtl/core/elg_checker.sv @@
// ============================================================================
// elg_checker
// Port-level checks on the cipher unit's command and result channels.
// ============================================================================
`default_nettype none
module elg_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire elg_pkg::rsp_type rsp_data
);
   // a transfer makes the unit busy next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy did not rise");
   // a result strobe lasts one cycle
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("strobe too long");
   // the unit is idle when the result comes out
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   // a result strobe comes with the fall of busy
   a_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("busy ended without result");
   // result fields are known whenever the strobe is up
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data)) else $error("unknown result data");
endmodule

bind elgamal_modexp_cipher elg_checker u_elg_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
`default_nettype wire
